// ===== hdl/cfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the checked frame deframer.
// No dependencies; every other file in hdl but cfd_chan_if imports this package.
package cfd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [0:0] {
    REG_START_BYTE  = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } cfd_reg_t;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } cfd_phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_FRAME_OK = 3'd1,
    EV_HDR_FAIL = 3'd2,
    EV_PAY_FAIL = 3'd3,
    EV_OVERSIZE = 3'd4
  } cfd_event_t;

  localparam logic [2:0] HdrFirstPos = 3'd1;
  localparam logic [2:0] HdrLastPos  = 3'd7;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] max_payload;
  } cfd_cfg_t;

  typedef struct packed {
    cfd_event_t  event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_id;
    logic [15:0] frame_type;
    logic [15:0] frame_length;
    logic [31:0] good_frames;
    logic [31:0] check_failures;
  } cfd_result_t;

endpackage

// ===== hdl/cfd_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and deframer results.
// Depends on nothing; used by the top level and the checker binding.
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_id;
  logic [15:0] frame_type;
  logic [15:0] frame_length;
  logic [31:0] good_frames;
  logic [31:0] check_failures;

  modport source (
    output valid, output event_kind, output payload_byte, output byte_index,
    output frame_id, output frame_type, output frame_length,
    output good_frames, output check_failures, input ready
  );
  modport sink (
    input valid, input event_kind, input payload_byte, input byte_index,
    input frame_id, input frame_type, input frame_length,
    input good_frames, input check_failures, output ready
  );
endinterface

// ===== hdl/cfd_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers: start byte and payload length limit.
// Depends on cfd_pkg.
module cfd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfd_pkg::CfgAddrW-1:0] paddr,
  input  logic [cfd_pkg::CfgDataW-1:0] pwdata,
  output logic [cfd_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  output cfd_pkg::cfd_cfg_t            cfg
);
  import cfd_pkg::*;

  cfd_cfg_t cfg_r;
  cfd_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfd_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= 8'd1;
      cfg_r.max_payload <= 16'd1024;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START_BYTE:  cfg_r.start_byte  <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg_r.max_payload <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_BYTE:  prdata = {24'd0, cfg_r.start_byte};
      REG_MAX_PAYLOAD: prdata = {16'd0, cfg_r.max_payload};
    endcase
  end
endmodule

// ===== hdl/cfd_parser.sv =====
`timescale 1ns / 1ps
// Frame parser: phase state machine, header and payload checks, counters.
// Depends on cfd_pkg; produces at most one result per accepted byte.
module cfd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfd_pkg::cfd_cfg_t     cfg,
  input  logic                  byte_acc,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output cfd_pkg::cfd_result_t  res
);
  import cfd_pkg::*;

  cfd_phase_t  phase_r, phase_nxt;
  logic [2:0]  pos_r;
  logic [7:0]  hx_r;
  logic [15:0] id_r, len_r, type_r;
  logic [15:0] cnt_r;
  logic [7:0]  px_r;
  logic [31:0] good_r, good_nxt;
  logic [31:0] fail_r, fail_nxt;
  logic [15:0] cnt_inc;
  logic        hdr_last, hdr_ok, pay_ok, too_long, is_start;
  cfd_event_t  kind;

  assign cnt_inc  = cnt_r + 16'd1;
  assign hdr_last = (pos_r == HdrLastPos);
  assign hdr_ok   = (rx_byte == ~hx_r);
  assign pay_ok   = (rx_byte == ~px_r);
  assign too_long = (len_r > cfg.max_payload);
  assign is_start = (rx_byte == cfg.start_byte);

  always_comb begin
    phase_nxt = phase_r;
    if (byte_acc) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (is_start) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          if (hdr_last) begin
            phase_nxt = (hdr_ok && (len_r != 16'd0) && !too_long) ? PH_DATA : PH_WAIT;
          end
        end
        PH_DATA: begin
          if (cnt_inc == len_r) phase_nxt = PH_CHECK;
        end
        PH_CHECK: phase_nxt = PH_WAIT;
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    kind      = EV_PAYLOAD;
    if (byte_acc) begin
      unique case (phase_r)
        PH_WAIT: res_valid = 1'b0;
        PH_HEADER: begin
          if (hdr_last) begin
            res_valid = 1'b1;
            priority if (!hdr_ok) kind = EV_HDR_FAIL;
            else if (len_r == 16'd0) kind = EV_FRAME_OK;
            else if (too_long) kind = EV_OVERSIZE;
            else res_valid = 1'b0;
          end
        end
        PH_DATA: res_valid = 1'b1;
        PH_CHECK: begin
          res_valid = 1'b1;
          kind      = pay_ok ? EV_FRAME_OK : EV_PAY_FAIL;
        end
      endcase
    end
  end

  always_comb begin
    good_nxt = good_r;
    fail_nxt = fail_r;
    if (res_valid && (kind == EV_FRAME_OK)) good_nxt = good_r + 32'd1;
    if (res_valid && ((kind == EV_HDR_FAIL) || (kind == EV_PAY_FAIL))) begin
      fail_nxt = fail_r + 32'd1;
    end
    res.event_kind     = kind;
    res.payload_byte   = (phase_r == PH_DATA) ? rx_byte : 8'd0;
    res.byte_index     = (phase_r == PH_DATA) ? cnt_r : 16'd0;
    res.frame_id       = id_r;
    res.frame_type     = type_r;
    res.frame_length   = len_r;
    res.good_frames    = good_nxt;
    res.check_failures = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      pos_r   <= 3'd0;
      hx_r    <= 8'd0;
      id_r    <= 16'd0;
      len_r   <= 16'd0;
      type_r  <= 16'd0;
      cnt_r   <= 16'd0;
      px_r    <= 8'd0;
      good_r  <= 32'd0;
      fail_r  <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      good_r  <= good_nxt;
      fail_r  <= fail_nxt;
      if (byte_acc) begin
        unique case (phase_r)
          PH_WAIT: begin
            if (is_start) begin
              hx_r  <= rx_byte;
              pos_r <= HdrFirstPos;
            end
          end
          PH_HEADER: begin
            if (!hdr_last) begin
              hx_r  <= hx_r ^ rx_byte;
              pos_r <= pos_r + 3'd1;
              case (pos_r)
                3'd1:    id_r[15:8]   <= rx_byte;
                3'd2:    id_r[7:0]    <= rx_byte;
                3'd3:    len_r[15:8]  <= rx_byte;
                3'd4:    len_r[7:0]   <= rx_byte;
                3'd5:    type_r[15:8] <= rx_byte;
                3'd6:    type_r[7:0]  <= rx_byte;
                default: ;
              endcase
            end else begin
              pos_r <= 3'd0;
              cnt_r <= 16'd0;
              px_r  <= 8'd0;
            end
          end
          PH_DATA: begin
            px_r  <= px_r ^ rx_byte;
            cnt_r <= cnt_inc;
          end
          PH_CHECK: ;
        endcase
      end
    end
  end
endmodule

// ===== hdl/cfd_out_stage.sv =====
`timescale 1ns / 1ps
// Output register with a skid entry so the input side sees a registered ready.
// Depends on cfd_pkg for the result record.
module cfd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cfd_pkg::cfd_result_t  push_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfd_pkg::cfd_result_t  out_data
);
  import cfd_pkg::*;

  cfd_result_t main_r, skid_r;
  logic        main_v_r, skid_v_r;
  logic        pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r   <= push_data;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= push_data;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end
endmodule

// ===== hdl/checked_frame_deframer.sv =====
`timescale 1ns / 1ps
// Byte-serial deframer for checked frames; one received byte is accepted per
// cycle while ready is high, and any result is registered by the output stage.
// Depends on cfd_pkg, cfd_chan_if, cfd_cfg_regs, cfd_parser and cfd_out_stage.
//
// The block hunts for the configured start byte, collects an 8-byte header
// (start, id, length, type, inverted-XOR check), then streams each payload
// byte out as it arrives and closes the frame with a status result: frame
// accepted, header or payload check failure, or oversize drop. Streamed bytes
// must be kept or discarded by the consumer according to that status. The
// sustained rate is one byte per clock while the result consumer keeps up;
// a two-entry output stage takes one more result into its skid entry once the
// result consumer stalls, and input ready drops only when both entries hold.
module checked_frame_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  cfd_in_if.sink                       in_chan,
  cfd_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfd_pkg::CfgAddrW-1:0] paddr,
  input  logic [cfd_pkg::CfgDataW-1:0] pwdata,
  output logic [cfd_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import cfd_pkg::*;

  cfd_cfg_t    cfg;
  cfd_result_t res, out_res;
  logic        res_valid, byte_acc, space;

  assign in_chan.ready = space;
  assign byte_acc      = in_chan.valid && space;

  cfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_acc  (byte_acc),
    .rx_byte   (in_chan.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  cfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_res)
  );

  assign out_chan.event_kind     = out_res.event_kind;
  assign out_chan.payload_byte   = out_res.payload_byte;
  assign out_chan.byte_index     = out_res.byte_index;
  assign out_chan.frame_id       = out_res.frame_id;
  assign out_chan.frame_type     = out_res.frame_type;
  assign out_chan.frame_length   = out_res.frame_length;
  assign out_chan.good_frames    = out_res.good_frames;
  assign out_chan.check_failures = out_res.check_failures;
endmodule

// ===== hdl/cfd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the checked frame deframer, bound to its top level.
// Depends on cfd_pkg and checked_frame_deframer.
module cfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [7:0]  payload_byte,
  input logic [15:0] byte_index,
  input logic [15:0] frame_length
);
  import cfd_pkg::*;

  logic is_payload;
  assign is_payload = (event_kind == EV_PAYLOAD);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(byte_index))
    else $error("Stalled result changed or vanished.");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_payload |-> (payload_byte == 8'd0) && (byte_index == 16'd0))
    else $error("Status result carries payload position or data.");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_payload |-> byte_index < frame_length)
    else $error("Payload byte index is beyond the declared length.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Output not empty or input not ready after reset.");
endmodule

bind checked_frame_deframer cfd_checker u_cfd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .event_kind   (out_chan.event_kind),
  .payload_byte (out_chan.payload_byte),
  .byte_index   (out_chan.byte_index),
  .frame_length (out_chan.frame_length)
);

// ===== dv/checked_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for checked_frame_deframer: queued received bytes,
// a bit-accurate deframing predictor and a result checker on the output channel.
// Depends on cfd_pkg, cfd_chan_if and the deframer RTL.
module checked_frame_deframer_tb;
  import cfd_pkg::*;

  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned SETTLE_LIMIT = 20000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SEG_BYTES = 280;

  typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_PAYLOAD} frame_flaw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic tx_valid = 1'b0;
  logic [7:0] tx_byte = '0;
  logic rx_ready = 1'b0;
  logic rx_long_hold = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  event rx_stall_ev;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned frame_bytes = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned config_writes = 0;
  int unsigned kind_count [5];

  logic [7:0] byte_backlog [$];
  cfd_result_t expected_events [$];

  logic [7:0] seg_start [5] = '{8'hA5, 8'h00, 8'hFF, 8'h3C, 8'h5A};
  logic [15:0] seg_max [5] = '{16'd20, 16'hFFFF, 16'd0, 16'd8, 16'd1};

  // Predictor copy of the registers and the parser state.
  logic [7:0] cfg_start = 8'd1;
  logic [15:0] cfg_max = 16'd1024;
  cfd_phase_t parse_state = PH_WAIT;
  logic [2:0] hdr_pos = '0;
  logic [7:0] hdr_xor = '0;
  logic [15:0] hdr_id = '0;
  logic [15:0] hdr_len = '0;
  logic [15:0] hdr_type = '0;
  logic [15:0] pay_count = '0;
  logic [7:0] pay_xor = '0;
  logic [31:0] frames_ok = '0;
  logic [31:0] check_errs = '0;

  cfd_in_if in_bus();
  cfd_out_if out_bus();

  assign in_bus.valid = tx_valid;
  assign in_bus.rx_byte = tx_byte;
  assign out_bus.ready = rx_ready;

  checked_frame_deframer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_bus),
    .out_chan(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfd_result_t frame_event(cfd_event_t kind, logic [7:0] pb,
                                              logic [15:0] idx);
    cfd_result_t r;
    r.event_kind = kind;
    r.payload_byte = pb;
    r.byte_index = idx;
    r.frame_id = hdr_id;
    r.frame_type = hdr_type;
    r.frame_length = hdr_len;
    r.good_frames = frames_ok;
    r.check_failures = check_errs;
    return r;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    case (parse_state)
      PH_WAIT: begin
        if (b == cfg_start) begin
          hdr_xor = b;
          hdr_pos = HdrFirstPos;
          parse_state = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (hdr_pos != HdrLastPos) begin
          hdr_xor ^= b;
          case (hdr_pos)
            3'd1: hdr_id[15:8] = b;
            3'd2: hdr_id[7:0] = b;
            3'd3: hdr_len[15:8] = b;
            3'd4: hdr_len[7:0] = b;
            3'd5: hdr_type[15:8] = b;
            default: hdr_type[7:0] = b;
          endcase
          hdr_pos = hdr_pos + 3'd1;
        end else begin
          hdr_pos = '0;
          parse_state = PH_WAIT;
          if (b != 8'(~hdr_xor)) begin
            check_errs = check_errs + 1;
            expected_events.push_back(frame_event(EV_HDR_FAIL, '0, '0));
          end else if (hdr_len == 16'd0) begin
            frames_ok = frames_ok + 1;
            expected_events.push_back(frame_event(EV_FRAME_OK, '0, '0));
          end else if (hdr_len > cfg_max) begin
            expected_events.push_back(frame_event(EV_OVERSIZE, '0, '0));
          end else begin
            pay_count = '0;
            pay_xor = '0;
            parse_state = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        expected_events.push_back(frame_event(EV_PAYLOAD, b, pay_count));
        pay_xor ^= b;
        pay_count = pay_count + 16'd1;
        if (pay_count == hdr_len) begin
          parse_state = PH_CHECK;
        end
      end
      default: begin
        parse_state = PH_WAIT;
        if (b == 8'(~pay_xor)) begin
          frames_ok = frames_ok + 1;
          expected_events.push_back(frame_event(EV_FRAME_OK, '0, '0));
        end else begin
          check_errs = check_errs + 1;
          expected_events.push_back(frame_event(EV_PAY_FAIL, '0, '0));
        end
      end
    endcase
  endfunction

  function automatic string describe(cfd_result_t r);
    return $sformatf("kind=%0d byte=%02h idx=%0d id=%04h type=%04h len=%0d good=%0d fail=%0d",
                     r.event_kind, r.payload_byte, r.byte_index, r.frame_id, r.frame_type,
                     r.frame_length, r.good_frames, r.check_failures);
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  // Byte requests leave the backlog in order; a request stays up until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_valid <= 1'b0;
    end else begin
      if (tx_valid && in_bus.ready) begin
        deframe_byte(tx_byte);
        bytes_accepted++;
      end
      if (!tx_valid || in_bus.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_valid <= 1'b1;
          tx_byte <= byte_backlog.pop_front();
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cfd_result_t seen;
    cfd_result_t want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_bus.valid && rx_ready) begin
        seen.event_kind = cfd_event_t'(out_bus.event_kind);
        seen.payload_byte = out_bus.payload_byte;
        seen.byte_index = out_bus.byte_index;
        seen.frame_id = out_bus.frame_id;
        seen.frame_type = out_bus.frame_type;
        seen.frame_length = out_bus.frame_length;
        seen.good_frames = out_bus.good_frames;
        seen.check_failures = out_bus.check_failures;
        results_seen++;
        if (out_bus.event_kind < 3'd5) begin
          kind_count[out_bus.event_kind]++;
        end
        if (expected_events.size() == 0) begin
          report_failure({"unexpected result ", describe(seen)});
        end else begin
          want = expected_events.pop_front();
          if (seen !== want) begin
            report_failure({"mismatch\n  expected ", describe(want),
                            "\n  actual   ", describe(seen)});
          end
        end
      end
      rx_ready <= !rx_long_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(rx_stall_ev) begin
    rx_long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_long_hold <= 1'b0;
  end

  task automatic push_byte(logic [7:0] b, bit counted);
    byte_backlog.push_back(b);
    bytes_queued++;
    if (counted) begin
      frame_bytes++;
    end
  endtask

  task automatic queue_frame(logic [15:0] id, logic [15:0] ftype, logic [15:0] len,
                             frame_flaw_t flaw);
    logic [7:0] hdr [7];
    logic [7:0] sum;
    logic [7:0] pb;
    hdr = '{cfg_start, id[15:8], id[7:0], len[15:8], len[7:0], ftype[15:8], ftype[7:0]};
    sum = '0;
    foreach (hdr[i]) begin
      sum ^= hdr[i];
      push_byte(hdr[i], 1'b1);
    end
    sum = ~sum;
    if (flaw == FLAW_HEADER) begin
      sum ^= 8'($urandom_range(1, 255));
    end
    push_byte(sum, 1'b1);
    if (flaw == FLAW_HEADER || len == 16'd0 || len > cfg_max) begin
      return;
    end
    sum = '0;
    repeat (len) begin
      pb = 8'($urandom);
      sum ^= pb;
      push_byte(pb, 1'b1);
    end
    sum = ~sum;
    if (flaw == FLAW_PAYLOAD) begin
      sum ^= 8'($urandom_range(1, 255));
    end
    push_byte(sum, 1'b1);
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned span;
    logic [15:0] len;
    logic [7:0] junk;
    frame_flaw_t flaw;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        junk = 8'($urandom);
        if (junk == cfg_start) begin
          junk ^= 8'h80;
        end
        push_byte(junk, 1'b0);
      end
    end
    r = $urandom_range(99);
    span = (cfg_max < 16'd24) ? cfg_max : 24;
    len = (span == 0 || $urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, span));
    flaw = FLAW_NONE;
    if (r < 10) begin
      flaw = FLAW_HEADER;
    end else if (r < 20) begin
      flaw = FLAW_PAYLOAD;
    end else if (r < 26 && cfg_max != 16'hFFFF) begin
      len = 16'(cfg_max + 1 + $urandom_range(0, 65534 - cfg_max));
    end else if (r < 30) begin
      // A header cut short, so the next frame's bytes land inside it.
      push_byte(cfg_start, 1'b1);
      repeat ($urandom_range(0, 6)) push_byte(8'($urandom), 1'b1);
      return;
    end
    queue_frame(16'($urandom), 16'($urandom), len, flaw);
  endtask

  task automatic write_reg(cfd_reg_t idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_BYTE: cfg_start = value[7:0];
      default: cfg_max = value[15:0];
    endcase
    config_writes++;
  endtask

  // Waits until every queued byte is taken and every expected result is back, or a guard expires.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    while ((bytes_accepted != bytes_queued || expected_events.size() != 0) &&
           guard < SETTLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_events.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_events.size()));
      expected_events.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [7:0] held_back [$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    queue_frame(16'hFFFF, 16'hFFFF, 16'h0000, FLAW_NONE);
    queue_frame(16'h0000, 16'h0000, 16'hFFFF, FLAW_NONE);
    queue_frame(16'h0101, 16'h8001, 16'h0001, FLAW_PAYLOAD);
    queue_frame(16'h1234, 16'h00FF, 16'h0002, FLAW_HEADER);

    for (int seg = 0; seg < 5; seg++) begin
      settle();
      tx_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 64 : 0;
      rx_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 11 : 0;
      write_reg(REG_START_BYTE, CfgDataW'(seg_start[seg]));
      write_reg(REG_MAX_PAYLOAD, CfgDataW'(seg_max[seg]));
      if (seg == 1) begin
        -> rx_stall_ev;
        queue_frame(16'($urandom), 16'($urandom), 16'd48, FLAW_NONE);
        settle();
      end
      if (seg == 3) begin
        // Shrink the length limit while a header is half received.
        queue_frame(16'($urandom), 16'($urandom), 16'd6, FLAW_NONE);
        while (byte_backlog.size() > 5) held_back.push_front(byte_backlog.pop_back());
        bytes_queued -= held_back.size();
        settle();
        write_reg(REG_MAX_PAYLOAD, CfgDataW'(3));
        while (held_back.size() != 0) push_byte(held_back.pop_front(), 1'b0);
        settle();
        write_reg(REG_MAX_PAYLOAD, CfgDataW'(seg_max[seg]));
      end
      while (frame_bytes < SEG_BYTES * (seg + 1)) random_frame();
    end
    settle();

    $display("Fed %0d bytes under %0d register writes; checked %0d results.",
             bytes_accepted, config_writes, results_seen);
    $display("Results: %0d payload, %0d good, %0d header bad, %0d payload bad, %0d oversize.",
             kind_count[EV_PAYLOAD], kind_count[EV_FRAME_OK], kind_count[EV_HDR_FAIL],
             kind_count[EV_PAY_FAIL], kind_count[EV_OVERSIZE]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", expected_events.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== checked_frame_deframer.f =====
hdl/cfd_pkg.sv
hdl/cfd_chan_if.sv
hdl/cfd_cfg_regs.sv
hdl/cfd_parser.sv
hdl/cfd_out_stage.sv
hdl/checked_frame_deframer.sv
hdl/cfd_checker.sv
dv/checked_frame_deframer_tb.sv
